// ===== src/hcb_pkg.sv =====
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

    // Fixed field widths of the input and result words.
    localparam int SYM_BITS       = 3;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int CODE_BITS      = 7;
    localparam int LEN_BITS       = 3;

    // Width that holds any node or leaf index for up to sixteen symbols.
    localparam int IDX_EXT_BITS   = 5;

    // Operation codes carried in the mode field.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ENCODE  = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [SYM_BITS-1:0]       symbol;
        logic [IN_WEIGHT_BITS-1:0] weight;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic [SYM_BITS-1:0]  out_symbol;
        logic [CODE_BITS-1:0] code_bits;
        logic [LEN_BITS-1:0]  code_length;
        logic                 found;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_weight;
        logic lookup;
        logic build_start;
        logic scan_issue;
        logic merge;
        logic walk_step;
        logic leaf_write;
        logic set_ready;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last;
        logic merge_last;
        logic at_root;
        logic leaf_last;
        logic out_blocked;
    } t_status;

endpackage

// ===== src/huffman_code_builder_unit.sv =====
// Top level of the Huffman code builder: controller, datapath and ports.
// Weight loads and code lookups take one word per cycle while idle and the result register is
// not blocked; a lookup result appears in the output register in the cycle after acceptance.
// A weight marked last starts the tree build, which stalls input; each merge scans the nodes
// one per cycle through the weight RAM read port, then a leaf-to-root walk builds each code.
// Reset clears the controller and tree state; lookups report not found until a build ends.
module huffman_code_builder_unit #(
    parameter int NUM_SYMBOLS = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hcb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hcb_pkg::t_out_word o_out_word
);
    import hcb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing.
    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Storage and arithmetic.
    hcb_datapath #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== src/hcb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module hcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/hcb_ctrl.sv =====
// Controller state machine that sequences loads, lookups, tree merges and the code walk.
module hcb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hcb_pkg::t_in_word i_in_word,
    input  hcb_pkg::t_status  i_status,
    output hcb_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);
    import hcb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_accept;

    // Words are taken only when idle and the result register can make room.
    assign o_in_stall = (r_state != S_IDLE) || i_status.out_blocked;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Next state and command decode.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_weight = in_accept && (i_in_word.mode == MODE_LOAD);
                o_cmd.lookup      = in_accept && (i_in_word.mode == MODE_ENCODE);
                if (o_cmd.load_weight && i_in_word.last) begin
                    o_cmd.build_start = 1'b1;
                    n_state           = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read of the scan is compared in this cycle.
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = i_status.merge_last ? S_WALK : S_SCAN;
            end
            S_WALK: begin
                if (i_status.at_root) begin
                    o_cmd.leaf_write = 1'b1;
                    if (i_status.leaf_last) begin
                        o_cmd.set_ready = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_build_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.build_start |=> (r_state == S_SCAN))
        else $error("Build start did not enter the scan phase.");

    a_ready_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.set_ready |=> (r_state == S_IDLE))
        else $error("Finished build did not return to idle.");

    a_merge_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ($past(r_state) == S_DRAIN))
        else $error("Merge entered without draining the scan.");

endmodule

// ===== src/hcb_datapath.sv =====
// Datapath: weight store, minimum search, tree arrays, code walk and the result register.
module hcb_datapath #(
    parameter int NUM_SYMBOLS = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcb_pkg::t_in_word  i_in_word,
    input  hcb_pkg::t_cmd      i_cmd,
    output hcb_pkg::t_status   o_status,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output hcb_pkg::t_out_word o_out_word
);
    import hcb_pkg::*;

    localparam int NODE_COUNT = 2 * NUM_SYMBOLS - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LEAF_W     = $clog2(NUM_SYMBOLS);
    localparam int LEN_W      = $clog2(NUM_SYMBOLS);
    localparam int NW         = WEIGHT_BITS + $clog2(NUM_SYMBOLS);
    localparam logic [NODE_W-1:0] ROOT = NODE_W'(NODE_COUNT - 1);

    // Tree structure, cleared at reset and at the start of every build.
    logic              r_node_used     [NODE_COUNT];
    logic [NODE_W-1:0] r_node_parent   [NODE_COUNT];
    logic              r_node_is_right [NODE_COUNT];

    // Stored codes per leaf.
    logic [CODE_BITS-1:0] r_leaf_code [NUM_SYMBOLS];
    logic [LEN_BITS-1:0]  r_leaf_len  [NUM_SYMBOLS];

    // Build counters and search state.
    logic [NODE_W-1:0] r_merge_idx;
    logic [NODE_W-1:0] r_scan_addr;
    logic [NODE_W-1:0] r_scan_node;
    logic              r_rd_valid;
    logic              r_have1;
    logic              r_have2;
    logic [NW-1:0]     r_min1_w;
    logic [NW-1:0]     r_min2_w;
    logic [NODE_W-1:0] r_min1_idx;
    logic [NODE_W-1:0] r_min2_idx;

    // Code walk state.
    logic [LEAF_W-1:0]    r_leaf_idx;
    logic [NODE_W-1:0]    r_walk_node;
    logic [LEN_W-1:0]     r_walk_len;
    logic [CODE_BITS-1:0] r_walk_code;

    logic      r_tree_ready;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic [IDX_EXT_BITS-1:0] sym_ext;
    logic                    sym_in_range;
    logic [31:0]             weight_ext;
    logic [IDX_EXT_BITS-1:0] len_ext;
    logic [LEAF_W-1:0]       leaf_next;
    logic [NW:0]             merge_sum;
    logic                    ram_wr_en;
    logic [NODE_W-1:0]       ram_wr_addr;
    logic [NW-1:0]           ram_wr_data;
    logic [NW-1:0]           ram_rd_data;
    logic                    cand;
    logic                    take1;
    logic                    take2;

    // Input decode.
    assign sym_ext      = IDX_EXT_BITS'(i_in_word.symbol);
    assign sym_in_range = sym_ext < IDX_EXT_BITS'(NUM_SYMBOLS);
    assign weight_ext   = 32'(i_in_word.weight);
    assign len_ext      = IDX_EXT_BITS'(r_walk_len);
    assign leaf_next    = r_leaf_idx + LEAF_W'(1);
    assign merge_sum    = {1'b0, r_min1_w} + {1'b0, r_min2_w};

    // Node weight store: leaves are written by loads, merged nodes by the build.
    assign ram_wr_en   = (i_cmd.load_weight && sym_in_range) || i_cmd.merge;
    assign ram_wr_addr = i_cmd.merge ? r_merge_idx : sym_ext[NODE_W-1:0];
    assign ram_wr_data = i_cmd.merge ? merge_sum[NW-1:0]
                                     : NW'(weight_ext[WEIGHT_BITS-1:0]);

    hcb_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.scan_issue),
        .i_rd_addr (r_scan_addr),
        .o_rd_data (ram_rd_data)
    );

    // Running two-minimum search; strict compares keep ties on the lower index.
    assign cand  = r_rd_valid && !r_node_used[r_scan_node];
    assign take1 = cand && (!r_have1 || (ram_rd_data < r_min1_w));
    assign take2 = cand && !take1 && (!r_have2 || (ram_rd_data < r_min2_w));

    // Status to the controller.
    assign o_status.scan_last   = (r_scan_addr == (r_merge_idx - NODE_W'(1)));
    assign o_status.merge_last  = (r_merge_idx == ROOT);
    assign o_status.at_root     = (r_walk_node == ROOT);
    assign o_status.leaf_last   = (r_leaf_idx == LEAF_W'(NUM_SYMBOLS - 1));
    assign o_status.out_blocked = r_out_valid && i_out_stall;

    // Control state: counters, flags and tree structure.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NODE_COUNT; n++) begin
                r_node_used[n]     <= 1'b0;
                r_node_parent[n]   <= '0;
                r_node_is_right[n] <= 1'b0;
            end
            r_merge_idx  <= '0;
            r_scan_addr  <= '0;
            r_rd_valid   <= 1'b0;
            r_have1      <= 1'b0;
            r_have2      <= 1'b0;
            r_leaf_idx   <= '0;
            r_walk_node  <= '0;
            r_walk_len   <= '0;
            r_tree_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_issue;
            if (i_cmd.scan_issue) begin
                r_scan_addr <= r_scan_addr + NODE_W'(1);
            end

            if (i_cmd.build_start) begin
                for (int n = 0; n < NODE_COUNT; n++) begin
                    r_node_used[n]     <= 1'b0;
                    r_node_parent[n]   <= '0;
                    r_node_is_right[n] <= 1'b0;
                end
                r_merge_idx <= NODE_W'(NUM_SYMBOLS);
                r_scan_addr <= '0;
                r_have1     <= 1'b0;
                r_have2     <= 1'b0;
                r_leaf_idx  <= '0;
            end else if (i_cmd.merge) begin
                // First pick becomes the left child, second the right child.
                r_node_used[r_min1_idx]     <= 1'b1;
                r_node_used[r_min2_idx]     <= 1'b1;
                r_node_parent[r_min1_idx]   <= r_merge_idx;
                r_node_parent[r_min2_idx]   <= r_merge_idx;
                r_node_is_right[r_min1_idx] <= 1'b0;
                r_node_is_right[r_min2_idx] <= 1'b1;
                r_merge_idx                 <= r_merge_idx + NODE_W'(1);
                r_scan_addr                 <= '0;
                r_have1                     <= 1'b0;
                r_have2                     <= 1'b0;
                r_walk_node                 <= NODE_W'(r_leaf_idx);
                r_walk_len                  <= '0;
            end else if (take1) begin
                r_have1 <= 1'b1;
                r_have2 <= r_have1;
            end else if (take2) begin
                r_have2 <= 1'b1;
            end

            // Walk from a leaf up to the root, then move on to the next leaf.
            if (i_cmd.walk_step) begin
                r_walk_node <= r_node_parent[r_walk_node];
                r_walk_len  <= r_walk_len + LEN_W'(1);
            end else if (i_cmd.leaf_write) begin
                r_leaf_idx  <= leaf_next;
                r_walk_node <= NODE_W'(leaf_next);
                r_walk_len  <= '0;
            end

            if (i_cmd.load_weight) begin
                r_tree_ready <= 1'b0;
            end else if (i_cmd.set_ready) begin
                r_tree_ready <= 1'b1;
            end

            if (i_cmd.lookup) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: minima, code under construction, code table and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_scan_node <= r_scan_addr;
        end

        if (take1) begin
            r_min2_w   <= r_min1_w;
            r_min2_idx <= r_min1_idx;
            r_min1_w   <= ram_rd_data;
            r_min1_idx <= r_scan_node;
        end else if (take2) begin
            r_min2_w   <= ram_rd_data;
            r_min2_idx <= r_scan_node;
        end

        // Code bits collect leaf first; only the low bits are kept.
        if (i_cmd.merge || i_cmd.leaf_write) begin
            r_walk_code <= '0;
        end else if (i_cmd.walk_step && (len_ext < IDX_EXT_BITS'(CODE_BITS))) begin
            r_walk_code[len_ext[LEN_BITS-1:0]] <= r_node_is_right[r_walk_node];
        end

        if (i_cmd.leaf_write) begin
            r_leaf_code[r_leaf_idx] <= r_walk_code;
            r_leaf_len[r_leaf_idx]  <= len_ext[LEN_BITS-1:0];
        end

        if (i_cmd.lookup) begin
            r_out_word.out_symbol <= i_in_word.symbol;
            if (r_tree_ready && sym_in_range) begin
                r_out_word.code_bits   <= r_leaf_code[sym_ext[LEAF_W-1:0]];
                r_out_word.code_length <= r_leaf_len[sym_ext[LEAF_W-1:0]];
                r_out_word.found       <= 1'b1;
            end else begin
                r_out_word.code_bits   <= '0;
                r_out_word.code_length <= '0;
                r_out_word.found       <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_merge_has_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_have1 && r_have2))
        else $error("Merge issued without two unused nodes.");

    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_min1_idx != r_min2_idx))
        else $error("Merge picked the same node twice.");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (32'(r_walk_len) < (NUM_SYMBOLS - 1)))
        else $error("Code walk ran deeper than the tree can be.");

endmodule
